[sv/pending_index_range_coalescer_macros.svh]
// ----------------------------------------------------------------------------
// Pending index range coalescer: assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PENDING_INDEX_RANGE_COALESCER_MACROS_SVH
`define PENDING_INDEX_RANGE_COALESCER_MACROS_SVH

`ifndef SYNTHESIS
`define PIRC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PIRC_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PIRC_ASSERT(name, clk, rst, prop, msg)
`define PIRC_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

[sv/pirc_pkg.sv]
// ----------------------------------------------------------------------------
// Pending index range coalescer: package
// Widths, word types, controller states and the scan interface struct.
// ----------------------------------------------------------------------------
package pirc_pkg;

   localparam int MAX_SLOTS   = 64;
   localparam int SLOT_W      = 6;
   localparam int CAP_W       = 7;
   localparam int CNT_W       = 7;
   localparam int ROW_BITS    = 8;
   localparam int COL_W       = 3;
   localparam int ROWS        = MAX_SLOTS / ROW_BITS;
   localparam int ROW_ADDR_W  = SLOT_W - COL_W;

   localparam logic [CAP_W-1:0]  CAP_LIMIT = CAP_W'(MAX_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(ROW_BITS - 1);

   localparam logic MODE_MARK  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SLOT_W-1:0] slot_index;
      logic              batch_open;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] span_first;
      logic [CNT_W-1:0]  span_len;
      logic              last_range;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MK_WR,
      ST_FL_RD,
      ST_FL_SCAN,
      ST_FL_END
   } state_type;

   typedef struct packed {
      logic              clear_run;
      logic              active;
      logic              bit_set;
      logic [SLOT_W-1:0] index;
      logic              last_bit;
      logic              finish;
   } scan_type;

endpackage

[sv/pirc_ram.sv]
// ----------------------------------------------------------------------------
// Pending index range coalescer: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pirc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/pirc_ctrl.sv]
// ----------------------------------------------------------------------------
// Pending index range coalescer: bitmap controller
// Holds the bitmap in a row RAM with per-row valid bits, runs mark
// read-modify-write and the bit-serial flush scan.
// ----------------------------------------------------------------------------
`include "pending_index_range_coalescer_macros.svh"

module pirc_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  pirc_pkg::req_type                req_data,
   output logic                             busy,
   input  logic                             csr_wr_en,
   input  logic [pirc_pkg::CAP_W-1:0]       csr_wr_data,
   output pirc_pkg::scan_type               scan
);

   pirc_pkg::state_type state_ff, state_in;
   logic [pirc_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [pirc_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [pirc_pkg::ROWS-1:0]   row_vld_ff, row_vld_in;
   logic [pirc_pkg::SLOT_W-1:0] idx_ff, idx_in;

   logic [pirc_pkg::CAP_W-1:0]      cap_eff;
   logic                            accept;
   logic [pirc_pkg::ROW_ADDR_W-1:0] row;
   logic [pirc_pkg::COL_W-1:0]      col;
   logic [pirc_pkg::ROW_BITS-1:0]   rd_data;
   logic [pirc_pkg::ROW_BITS-1:0]   row_data;
   logic                            cur_bit;
   logic                            rd_en;
   logic [pirc_pkg::ROW_ADDR_W-1:0] rd_addr;
   logic                            wr_en;
   logic [pirc_pkg::ROW_BITS-1:0]   wr_data;

   assign cap_eff  = (cap_ff > pirc_pkg::CAP_LIMIT) ? pirc_pkg::CAP_LIMIT : cap_ff;
   assign accept   = start && !busy;
   assign busy     = (state_ff != pirc_pkg::ST_IDLE);
   assign row      = idx_ff[pirc_pkg::SLOT_W-1:pirc_pkg::COL_W];
   assign col      = idx_ff[pirc_pkg::COL_W-1:0];
   // a row never written since the last clear reads as empty
   assign row_data = row_vld_ff[row] ? rd_data : '0;
   assign cur_bit  = row_data[col];

   assign rd_en   = (accept && req_data.mode == pirc_pkg::MODE_MARK)
                    || (state_ff == pirc_pkg::ST_FL_RD);
   assign rd_addr = (state_ff == pirc_pkg::ST_FL_RD) ? row
                    : req_data.slot_index[pirc_pkg::SLOT_W-1:pirc_pkg::COL_W];
   assign wr_en   = (state_ff == pirc_pkg::ST_MK_WR) && !cur_bit;
   assign wr_data = row_data | (pirc_pkg::ROW_BITS'(1) << col);

   pirc_ram #(
      .WIDTH (pirc_pkg::ROW_BITS),
      .DEPTH (pirc_pkg::ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pirc_pkg::ST_IDLE;
         cap_ff     <= pirc_pkg::CAP_LIMIT;
         count_ff   <= '0;
         row_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cap_ff     <= cap_in;
         count_ff   <= count_in;
         row_vld_ff <= row_vld_in;
      end
      idx_ff <= idx_in;
   end

   always_comb begin
      state_in   = state_ff;
      cap_in     = cap_ff;
      count_in   = count_ff;
      row_vld_in = row_vld_ff;
      idx_in     = idx_ff;
      case (state_ff)
         pirc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.mode == pirc_pkg::MODE_MARK) begin
                  // drop marks at or above the capacity in use
                  if ({1'b0, req_data.slot_index} < cap_eff) begin
                     state_in = pirc_pkg::ST_MK_WR;
                     idx_in   = req_data.slot_index;
                  end
               end else if (req_data.batch_open && count_ff != '0) begin
                  state_in = pirc_pkg::ST_FL_RD;
                  idx_in   = '0;
               end
            end
         end
         pirc_pkg::ST_MK_WR: begin
            if (!cur_bit) begin
               count_in        = count_ff + pirc_pkg::CNT_W'(1);
               row_vld_in[row] = 1'b1;
            end
            state_in = pirc_pkg::ST_IDLE;
         end
         pirc_pkg::ST_FL_RD: begin
            state_in = pirc_pkg::ST_FL_SCAN;
         end
         pirc_pkg::ST_FL_SCAN: begin
            idx_in = idx_ff + pirc_pkg::SLOT_W'(1);
            if (idx_ff == pirc_pkg::LAST_SLOT) begin
               state_in = pirc_pkg::ST_FL_END;
            end else if (col == pirc_pkg::LAST_COL) begin
               state_in = pirc_pkg::ST_FL_RD;
            end
         end
         pirc_pkg::ST_FL_END: begin
            row_vld_in = '0;
            count_in   = '0;
            state_in   = pirc_pkg::ST_IDLE;
         end
         default: begin
            state_in = pirc_pkg::ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         cap_in     = csr_wr_data;
         row_vld_in = '0;
         count_in   = '0;
      end
   end

   assign scan.clear_run = accept && (req_data.mode == pirc_pkg::MODE_FLUSH);
   assign scan.active    = (state_ff == pirc_pkg::ST_FL_SCAN);
   assign scan.bit_set   = cur_bit;
   assign scan.index     = idx_ff;
   assign scan.last_bit  = (idx_ff == pirc_pkg::LAST_SLOT);
   assign scan.finish    = (state_ff == pirc_pkg::ST_FL_END);

   `PIRC_ASSERT_NEVER(a_count_range, clock, reset, count_ff > pirc_pkg::CAP_LIMIT,
      "pending count above slot limit")
   `PIRC_ASSERT(a_flush_clears, clock, reset,
      (state_ff == pirc_pkg::ST_FL_END) |=> (count_ff == '0 && row_vld_ff == '0),
      "flush end left pending state")
   `PIRC_ASSERT(a_mark_counts, clock, reset,
      (state_ff == pirc_pkg::ST_MK_WR && !cur_bit && !csr_wr_en)
         |=> (count_ff == $past(count_ff) + pirc_pkg::CNT_W'(1)),
      "new mark not counted")

endmodule

[sv/pirc_run.sv]
// ----------------------------------------------------------------------------
// Pending index range coalescer: run tracker
// Builds runs from the scanned bits and holds one closed run back so the
// final one of a flush can be flagged.
// ----------------------------------------------------------------------------
`include "pending_index_range_coalescer_macros.svh"

module pirc_run (
   input  logic               clock,
   input  logic               reset,
   input  pirc_pkg::scan_type scan,
   output logic               rsp_strobe,
   output pirc_pkg::rsp_type  rsp_data
);

   logic [pirc_pkg::SLOT_W-1:0] run_start_ff, run_start_in;
   logic [pirc_pkg::CNT_W-1:0]  run_len_ff, run_len_in;
   logic                        held_vld_ff, held_vld_in;
   logic [pirc_pkg::SLOT_W-1:0] held_start_ff, held_start_in;
   logic [pirc_pkg::CNT_W-1:0]  held_len_ff, held_len_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   pirc_pkg::rsp_type           rsp_ff, rsp_in;

   logic [pirc_pkg::SLOT_W-1:0] new_start;
   logic [pirc_pkg::CNT_W-1:0]  new_len;
   logic                        close_old;
   logic                        close_new;

   assign new_start = (run_len_ff == '0) ? scan.index : run_start_ff;
   assign new_len   = run_len_ff + pirc_pkg::CNT_W'(1);
   assign close_old = scan.active && !scan.bit_set && run_len_ff != '0;
   assign close_new = scan.active && scan.bit_set && scan.last_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff  <= '0;
         held_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         run_len_ff  <= run_len_in;
         held_vld_ff <= held_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      run_start_ff  <= run_start_in;
      held_start_ff <= held_start_in;
      held_len_ff   <= held_len_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      held_vld_in   = held_vld_ff;
      held_start_in = held_start_ff;
      held_len_in   = held_len_ff;
      rsp_vld_in    = 1'b0;
      rsp_in        = rsp_ff;
      if (scan.clear_run) begin
         run_len_in  = '0;
         held_vld_in = 1'b0;
      end
      if (scan.active && scan.bit_set) begin
         run_start_in = new_start;
         run_len_in   = new_len;
      end
      if (close_old || close_new) begin
         // release the held run, hold the one just closed
         rsp_vld_in          = held_vld_ff;
         rsp_in.span_first   = held_start_ff;
         rsp_in.span_len     = held_len_ff;
         rsp_in.last_range   = 1'b0;
         held_vld_in         = 1'b1;
         held_start_in       = close_new ? new_start : run_start_ff;
         held_len_in         = close_new ? new_len : run_len_ff;
         run_len_in          = '0;
      end
      if (scan.finish) begin
         rsp_vld_in         = held_vld_ff;
         rsp_in.span_first  = held_start_ff;
         rsp_in.span_len    = held_len_ff;
         rsp_in.last_range  = 1'b1;
         held_vld_in        = 1'b0;
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   `PIRC_ASSERT(a_run_nonzero, clock, reset, rsp_vld_ff |-> (rsp_ff.span_len != '0),
      "empty run emitted")
   `PIRC_ASSERT(a_run_fits, clock, reset,
      rsp_vld_ff |-> ({1'b0, rsp_ff.span_first} + rsp_ff.span_len <= pirc_pkg::CAP_LIMIT),
      "run passes slot limit")

endmodule

[sv/pending_index_range_coalescer.sv]
// ----------------------------------------------------------------------------
// Pending index range coalescer
// Pending slot bitmap with mark and flush; a flush with batch_open set emits each run of
// contiguous pending slots as start and count, flags the final run, and
// clears the bitmap.
//
//   channel   ports                            handshake
//   --------  -------------------------------  ----------------------------
//   request   start, busy, req_data            taken when start && !busy
//   result    rsp_strobe, rsp_data             one-cycle strobe, no stall
//   csr       csr_wr_en, csr_wr_data           write when csr_wr_en
//
// A mark holds busy after the word is taken (row read, then write back
// through the bitmap RAM port); an out-of-range mark and a flush that does
// nothing never raise busy.
// A flush scans one slot per cycle plus one RAM read per 8-slot row, then
// clears the bitmap in ST_FL_END, with busy high throughout.
// Reset is synchronous; the bitmap reads empty right after reset through
// per-row valid bits, with no clearing pass. Capacity resets to 64.
// ----------------------------------------------------------------------------
module pending_index_range_coalescer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  pirc_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output pirc_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [pirc_pkg::CAP_W-1:0] csr_wr_data
);

   pirc_pkg::scan_type scan;

   pirc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .scan        (scan)
   );

   pirc_run u_run (
      .clock      (clock),
      .reset      (reset),
      .scan       (scan),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[verif/tb_pending_index_range_coalescer.sv]
// ----------------------------------------------------------------------------
// Pending index range coalescer: testbench
// Drives mark and flush words with random idle bursts and writes the capacity
// register between phases. The monitor keeps its own pending-slot bitmap,
// derives the runs each flush must emit, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_pending_index_range_coalescer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 200000;

   typedef enum int {
      FILL_ALL,
      ALTERNATE,
      RUNS,
      SPARSE
   } batch_shape_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   pirc_pkg::req_type              req_data = '0;
   logic                           rsp_strobe;
   pirc_pkg::rsp_type              rsp_data;
   logic                           csr_wr_en = 1'b0;
   logic [pirc_pkg::CAP_W-1:0]     csr_wr_data = '0;

   // driver and generator state
   pirc_pkg::req_type              cmd_words[$];
   logic                           took = 1'b0;
   logic                           no_idle = 1'b0;
   int                             idle_left = 0;
   int                             words_queued = 0;
   int                             cur_cap = pirc_pkg::MAX_SLOTS;

   // predictor state and checking
   logic [pirc_pkg::CAP_W-1:0]     capacity = pirc_pkg::CAP_LIMIT;
   logic [pirc_pkg::MAX_SLOTS-1:0] pending_slots = '0;
   logic [pirc_pkg::CNT_W-1:0]     pending_total = '0;
   pirc_pkg::rsp_type              expected_ranges[$];
   int                             mismatches = 0;
   int                             cycles = 0;

   pending_index_range_coalescer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Update the bitmap for one accepted word; a flush queues its runs.
   task automatic apply_word(input pirc_pkg::req_type w);
      int                lim;
      int                run_from;
      int                run_len;
      logic              have_held;
      pirc_pkg::rsp_type held;
      lim = (capacity > pirc_pkg::MAX_SLOTS) ? pirc_pkg::MAX_SLOTS : int'(capacity);
      run_from = 0;
      run_len = 0;
      have_held = 1'b0;
      held = '0;
      if (w.mode == pirc_pkg::MODE_MARK) begin
         if (w.slot_index < lim && !pending_slots[w.slot_index]) begin
            pending_slots[w.slot_index] = 1'b1;
            pending_total = pending_total + 1'b1;
         end
      end else if (w.batch_open && pending_total != 0) begin
         if (lim != 0) begin
            for (int i = 0; i <= lim; i++) begin
               if (i < lim && pending_slots[i]) begin
                  if (run_len == 0) run_from = i;
                  run_len++;
               end else if (run_len != 0) begin
                  // hold each run back until the next one proves it is not last
                  if (have_held) expected_ranges.insert(expected_ranges.size(), held);
                  held.span_first = pirc_pkg::SLOT_W'(run_from);
                  held.span_len = pirc_pkg::CNT_W'(run_len);
                  held.last_range = 1'b0;
                  have_held = 1'b1;
                  run_len = 0;
               end
            end
            if (have_held) begin
               held.last_range = 1'b1;
               expected_ranges.insert(expected_ranges.size(), held);
            end
         end
         pending_slots = '0;
         pending_total = '0;
      end
   endtask

   // Monitor: sample at the rising edge, predict on acceptance, check results.
   always @(posedge clock) begin
      pirc_pkg::rsp_type want;
      if (reset) begin
         took <= 1'b0;
         capacity = pirc_pkg::CAP_LIMIT;
         pending_slots = '0;
         pending_total = '0;
      end else begin
         took <= start && !busy;
         if (rsp_strobe) begin
            if (expected_ranges.size() == 0) begin
               report_mismatch($sformatf("unexpected range start %0d count %0d last %0b",
                  rsp_data.span_first, rsp_data.span_len, rsp_data.last_range));
            end else begin
               want = expected_ranges.pop_front();
               if (rsp_data.span_first !== want.span_first)
                  report_mismatch($sformatf("span_first %0d, want %0d",
                     rsp_data.span_first, want.span_first));
               if (rsp_data.span_len !== want.span_len)
                  report_mismatch($sformatf("span_len %0d, want %0d (start %0d)",
                     rsp_data.span_len, want.span_len, want.span_first));
               if (rsp_data.last_range !== want.last_range)
                  report_mismatch($sformatf("last_range %0b, want %0b (start %0d)",
                     rsp_data.last_range, want.last_range, want.span_first));
            end
         end
         if (csr_wr_en) begin
            capacity = csr_wr_data;
            pending_slots = '0;
            pending_total = '0;
         end
         if (start && !busy) apply_word(req_data);
      end
   end

   // Driver: change inputs at the falling edge, hold a word until it is taken.
   always @(negedge clock) begin
      pirc_pkg::req_type nxt;
      logic              go;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         go = 1'b0;
         nxt = pirc_pkg::req_type'($urandom);
         if (idle_left != 0) begin
            idle_left--;
         end else if (cmd_words.size() != 0) begin
            if (!no_idle && $urandom_range(0, 7) == 0) begin
               idle_left = $urandom_range(0, 11);
            end else begin
               nxt = cmd_words.pop_front();
               go = 1'b1;
            end
         end
         start <= go;
         req_data <= nxt;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_pending_index_range_coalescer failed");
         $finish;
      end
   end

   task automatic queue_mark(input int idx);
      pirc_pkg::req_type w;
      w.mode = pirc_pkg::MODE_MARK;
      w.slot_index = pirc_pkg::SLOT_W'(idx);
      w.batch_open = 1'($urandom_range(0, 1));
      cmd_words.insert(cmd_words.size(), w);
      words_queued++;
   endtask

   task automatic queue_flush(input logic open);
      pirc_pkg::req_type w;
      w.mode = pirc_pkg::MODE_FLUSH;
      w.slot_index = pirc_pkg::SLOT_W'($urandom_range(0, pirc_pkg::MAX_SLOTS - 1));
      w.batch_open = open;
      cmd_words.insert(cmd_words.size(), w);
      words_queued++;
   endtask

   // One batch: marks of the given shape, some noise, then usually a flush.
   task automatic queue_batch(input batch_shape_type shape);
      int lim;
      int off;
      int base;
      int len;
      int idx;
      lim = (cur_cap > pirc_pkg::MAX_SLOTS) ? pirc_pkg::MAX_SLOTS : cur_cap;
      case (shape)
         FILL_ALL: begin
            off = $urandom_range(0, pirc_pkg::MAX_SLOTS - 1);
            for (int j = 0; j < lim; j++) queue_mark((off + j) % lim);
         end
         ALTERNATE: begin
            for (int k = $urandom_range(0, 1); k < lim; k += 2) queue_mark(k);
         end
         RUNS: begin
            if (lim != 0) begin
               repeat ($urandom_range(1, 4)) begin
                  base = $urandom_range(0, lim - 1);
                  len = $urandom_range(1, 10);
                  for (int k = base; k < base + len && k < lim; k++) queue_mark(k);
               end
            end
         end
         default: begin
            repeat ($urandom_range(1, 10)) begin
               idx = $urandom_range(0, pirc_pkg::MAX_SLOTS - 1);
               queue_mark(idx);
               if ($urandom_range(0, 3) == 0) queue_mark(idx);
            end
         end
      endcase
      if ($urandom_range(0, 4) == 0) queue_flush(1'b0);
      if ($urandom_range(0, 7) != 0) queue_flush(1'b1);
   endtask

   task automatic fill_random(input int target);
      int r;
      while (words_queued < target) begin
         r = $urandom_range(0, 9);
         case (r)
            0:          queue_batch(FILL_ALL);
            1:          queue_batch(ALTERNATE);
            2, 3, 4, 5: queue_batch(RUNS);
            default:    queue_batch(SPARSE);
         endcase
      end
   endtask

   // Wait for every word taken and every result seen, then let the block settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_words.size() != 0 || start || busy || expected_ranges.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= pirc_pkg::CAP_W'(value);
      cur_cap = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset capacity: empty flush, duplicate, closed flush, runs at both ends
      queue_flush(1'b1);
      queue_mark(0);
      queue_mark(pirc_pkg::MAX_SLOTS - 1);
      queue_mark(0);
      queue_mark(5);
      queue_mark(6);
      queue_mark(7);
      queue_flush(1'b0);
      queue_flush(1'b1);

      // rewriting the same capacity drops what is pending
      queue_mark(4);
      write_capacity(pirc_pkg::MAX_SLOTS);
      queue_flush(1'b1);

      write_capacity(10);
      queue_mark(9);
      queue_mark(10);
      queue_mark(pirc_pkg::MAX_SLOTS - 1);
      queue_mark(9);
      queue_flush(1'b1);

      // uninitialized pool: every mark dropped
      write_capacity(0);
      queue_mark(3);
      queue_flush(1'b1);

      // capacity above the slot count acts as the slot count
      write_capacity(127);
      queue_mark(pirc_pkg::MAX_SLOTS - 1);
      queue_mark(pirc_pkg::MAX_SLOTS - 2);
      queue_mark(0);
      queue_flush(1'b1);

      write_capacity(1);
      queue_mark(1);
      queue_mark(0);
      queue_flush(1'b1);

      write_capacity(pirc_pkg::MAX_SLOTS);
      queue_batch(FILL_ALL);
      queue_batch(ALTERNATE);
      queue_flush(1'b1);
      fill_random(words_queued + 15);

      write_capacity($urandom_range(2, pirc_pkg::MAX_SLOTS - 1));
      fill_random(words_queued + 20);

      write_capacity($urandom_range(pirc_pkg::MAX_SLOTS + 1, 126));
      fill_random(words_queued + 15);

      write_capacity(2);
      fill_random(words_queued + 10);

      write_capacity(1);
      fill_random(words_queued + 10);

      write_capacity(0);
      fill_random(words_queued + 6);

      // last stretch back to back, no idling
      write_capacity(pirc_pkg::MAX_SLOTS);
      no_idle = 1'b1;
      fill_random(words_queued + 25);

      wait_idle();
      if (mismatches == 0) begin
         $display("tb_pending_index_range_coalescer passed");
      end else begin
         $display("tb_pending_index_range_coalescer failed");
      end
      $finish;
   end

endmodule
